FILE: design/msps_pkg.sv
// Shared types and constants of the multi-channel pulse scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package msps_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int MAX_CH = 4;
	localparam int FREQ_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int TICK_W = 32;
	localparam int POS_W = 32;
	localparam int LAST_W = 17;
	localparam int NEXT_W = 16;
	localparam int MASK_W = 4;
	localparam int QUO_W = 27;
	localparam int CNT_W = $clog2(QUO_W);

	localparam int TICK_RATE = 72000000;
	localparam int WAIT_CAP = 65535;
	localparam int WAIT_FLOOR = 700;
	localparam int WAIT_HALF_LIMIT = WAIT_CAP * 2;
	localparam int FREQ_RESET = 1000;

	typedef struct packed {
		logic init;
		logic sub;
		logic div_init;
		logic div_step;
		logic pulse;
		logic propose;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic le_zero;
		logic div_last;
		logic ch_last;
		logic out_busy;
	} stat_t;

endpackage

FILE: design/msps_ctrl.sv
// Sequencer of the pulse scheduler: walks the channels for each input word that carries an expiry event.
// Depends on msps_pkg; drives the datapath by cmd_t and reads stat_t.
module msps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           expiry_event,
	output msps_pkg::cmd_t cmd,
	input  msps_pkg::stat_t stat
);
	import msps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUB,
		S_CHECK,
		S_DIV,
		S_PULSE,
		S_PROPOSE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.init = accept && expiry_event;
			S_SUB:     cmd.sub = 1'b1;
			S_CHECK:   cmd.div_init = stat.le_zero;
			S_DIV:     cmd.div_step = 1'b1;
			S_PULSE:   cmd.pulse = 1'b1;
			S_PROPOSE: cmd.propose = 1'b1;
			S_FINISH:  cmd.finish = !stat.out_busy;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && expiry_event) state_q <= S_SUB;
				end
				S_SUB: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= stat.le_zero ? S_DIV : S_PROPOSE;
				end
				S_DIV: begin
					if (stat.div_last) state_q <= S_PULSE;
				end
				S_PULSE: state_q <= S_PROPOSE;
				S_PROPOSE: begin
					state_q <= stat.ch_last ? S_FINISH : S_SUB;
				end
				S_FINISH: begin
					if (!stat.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_to_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && stat.div_last) |=> (state_q == S_PULSE))
		else $error("divider end did not lead to pulse update");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!stat.out_busy && state_q == S_FINISH))
		else $error("result loaded while output word still held");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

endmodule

FILE: design/msps_dp.sv
// Datapath of the pulse scheduler: channel state, serial divider, output word.
// Depends on msps_pkg; steered by msps_ctrl through cmd_t and stat_t.
module msps_dp #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cfg_we,
	input  logic [msps_pkg::CFG_IDX_W-1:0]                 cfg_addr,
	input  logic [msps_pkg::FREQ_W-1:0]                    cfg_wdata,
	input  msps_pkg::cmd_t                                 cmd,
	output msps_pkg::stat_t                                stat,
	input  logic                                           out_ready,
	output logic                                           out_valid,
	output logic [msps_pkg::MASK_W-1:0]                    pulse_mask,
	output logic [msps_pkg::NEXT_W-1:0]                    next_interval,
	output logic [msps_pkg::MAX_CH-1:0][msps_pkg::POS_W-1:0] position
);
	import msps_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [FREQ_W-1:0]        freq_q  [CHANNELS];
	logic [TICK_W-1:0]        ticks_q [CHANNELS];
	logic [POS_W-1:0]         pos_q   [CHANNELS];
	logic [LAST_W-1:0]        last_q;
	logic [CH_W-1:0]          ch_q;
	logic [MASK_W-1:0]        mask_q;
	logic                     out_valid_q;

	logic signed [TICK_W-1:0] best_q;
	logic [FREQ_W-1:0]        rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [FREQ_W-1:0]        dsor_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MASK_W-1:0]        out_mask_q;
	logic [NEXT_W-1:0]        out_next_q;
	logic [POS_W-1:0]         out_pos_q [CHANNELS];

	logic [TICK_W-1:0]        cur_ticks;
	logic [TICK_W-1:0]        sub_ticks;
	logic signed [TICK_W-1:0] left;
	logic signed [TICK_W-1:0] wait_val;
	logic [NEXT_W-1:0]        next_val;
	logic [FREQ_W-1:0]        cur_freq;
	logic [FREQ_W:0]          shifted;
	logic                     ge;
	logic [FREQ_W:0]          diff;

	assign cur_ticks = ticks_q[ch_q];
	assign cur_freq  = freq_q[ch_q];
	assign sub_ticks = cur_ticks - TICK_W'(last_q);
	assign left      = $signed(cur_ticks);

	always_comb begin
		if (left >= WAIT_HALF_LIMIT) begin
			wait_val = TICK_W'(WAIT_CAP);
		end else if (left > WAIT_CAP) begin
			wait_val = left >>> 1;
		end else begin
			wait_val = left;
		end
	end

	always_comb begin
		if (best_q < WAIT_FLOOR) begin
			next_val = NEXT_W'(WAIT_FLOOR);
		end else if (best_q > WAIT_CAP) begin
			next_val = NEXT_W'(WAIT_CAP);
		end else begin
			next_val = best_q[NEXT_W-1:0];
		end
	end

	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign ge      = shifted >= {1'b0, dsor_q};
	assign diff    = shifted - {1'b0, dsor_q};

	assign stat.le_zero  = cur_ticks[TICK_W-1] || (cur_ticks == '0);
	assign stat.div_last = (cnt_q == CNT_W'(QUO_W - 1));
	assign stat.ch_last  = (ch_q == CH_W'(CHANNELS - 1));
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				freq_q[i]  <= FREQ_W'(FREQ_RESET);
				ticks_q[i] <= '0;
				pos_q[i]   <= '0;
			end
			last_q      <= '0;
			ch_q        <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (int'(cfg_addr) < CHANNELS)) begin
				freq_q[cfg_addr[CH_W-1:0]] <= cfg_wdata;
			end
			if (cmd.init) begin
				ch_q   <= '0;
				mask_q <= '0;
			end
			if (cmd.sub) begin
				ticks_q[ch_q] <= sub_ticks;
			end
			if (cmd.pulse) begin
				ticks_q[ch_q] <= cur_ticks + TICK_W'(quo_q);
				pos_q[ch_q]   <= pos_q[ch_q] + POS_W'(1);
				mask_q        <= mask_q | (MASK_W'(1) << ch_q);
			end
			if (cmd.propose && !stat.ch_last) begin
				ch_q <= ch_q + CH_W'(1);
			end
			// hold the word until taken; a new one may load in the same edge
			if (cmd.finish) begin
				last_q      <= LAST_W'(next_val);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			best_q <= TICK_W'(WAIT_CAP + 1);
		end else if (cmd.propose && (wait_val < best_q)) begin
			best_q <= wait_val;
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= QUO_W'(TICK_RATE);
			dsor_q <= (cur_freq == '0) ? FREQ_W'(1) : cur_freq;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.finish) begin
			out_mask_q <= mask_q;
			out_next_q <= next_val;
			for (int i = 0; i < CHANNELS; i++) begin
				out_pos_q[i] <= pos_q[i];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pulse_mask    = out_mask_q;
	assign next_interval = out_next_q;

	for (genvar i = 0; i < MAX_CH; i++) begin : g_pos
		if (i < CHANNELS) begin : g_used
			assign position[i] = out_pos_q[i];
		end else begin : g_unused
			assign position[i] = '0;
		end
	end

	a_next_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_next_q >= NEXT_W'(WAIT_FLOOR)))
		else $error("next interval below floor");

	a_pulse_mask: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pulse |=> (mask_q != '0))
		else $error("pulse left mask empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
			(out_valid_q && $stable(out_mask_q) && $stable(out_next_q)))
		else $error("output word changed before it was taken");

endmodule

FILE: design/multi_channel_pulse_scheduler.sv
// Per channel the sequencer steps through subtract, check and propose, adding a bit-serial
// 72000000/freq divide and a pulse update when the channel has expired.
// One word at a time: in_ready stays low from an expiry word until its result is loaded.
// Reset: arst_n clears time-left, positions and last interval, sets frequencies to 1000.
// Top level: msps_ctrl sequences, msps_dp holds state; depends on msps_pkg.
module multi_channel_pulse_scheduler #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [msps_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [msps_pkg::FREQ_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           expiry_event,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [msps_pkg::MASK_W-1:0]    pulse_mask,
	output logic [msps_pkg::NEXT_W-1:0]    next_interval,
	output logic [msps_pkg::POS_W-1:0]     position_0,
	output logic [msps_pkg::POS_W-1:0]     position_1,
	output logic [msps_pkg::POS_W-1:0]     position_2,
	output logic [msps_pkg::POS_W-1:0]     position_3
);
	import msps_pkg::*;

	cmd_t                          cmd;
	stat_t                         stat;
	logic [MAX_CH-1:0][POS_W-1:0]  position;

	msps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.expiry_event (expiry_event),
		.cmd          (cmd),
		.stat         (stat)
	);

	msps_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.pulse_mask    (pulse_mask),
		.next_interval (next_interval),
		.position      (position)
	);

	assign position_0 = position[0];
	assign position_1 = position[1];
	assign position_2 = position[2];
	assign position_3 = position[3];

endmodule

FILE: dv/tb.sv
// Testbench for multi_channel_pulse_scheduler: random and directed expiry words,
// frequency writes between phases, a per-channel schedule predictor and a scoreboard.
// Depends on msps_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module tb;
	import msps_pkg::*;

	localparam int CH = CHANNELS_DEF;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 224;
	localparam int DRAIN_CYCLES = 160;
	localparam int HOLD_AT = 700;
	localparam int HOLD_CYCLES = 800;
	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_0,
		REG_FREQ_1,
		REG_FREQ_2,
		REG_FREQ_3
	} freq_reg_e;

	typedef logic [MAX_CH-1:0][FREQ_W-1:0] freq_set_t;

	typedef struct packed {
		logic [MASK_W-1:0]            mask;
		logic [NEXT_W-1:0]            interval;
		logic [MAX_CH-1:0][POS_W-1:0] posn;
	} report_t;

	class schedule_board;
		logic [FREQ_W-1:0] freq [MAX_CH];
		logic [TICK_W-1:0] time_left [MAX_CH];
		logic [POS_W-1:0]  steps [MAX_CH];
		logic [LAST_W-1:0] last_ivl;
		report_t           pending_reports [$];
		int unsigned       errors;

		function new();
			for (int n = 0; n < MAX_CH; n++) begin
				freq[n] = FREQ_W'(FREQ_RESET);
				time_left[n] = '0;
				steps[n] = '0;
			end
			last_ivl = '0;
			errors = 0;
		endfunction

		function void set_freq(int idx, logic [FREQ_W-1:0] value);
			freq[idx] = value;
		endfunction

		function int unsigned waiting();
			return pending_reports.size();
		endfunction

		// walk the channels for one expiry and queue the schedule it yields
		function void note_word(logic ev);
			report_t want;
			longint lft, prop, best, period;
			logic [FREQ_W-1:0] fz;
			if (!ev)
				return;
			want = '0;
			best = longint'(WAIT_CAP + 1);
			for (int n = 0; n < CH; n++) begin
				time_left[n] = time_left[n] - {{(TICK_W-LAST_W){1'b0}}, last_ivl};
				if ($signed(time_left[n]) <= 0) begin
					fz = (freq[n] == '0) ? FREQ_W'(1) : freq[n];
					period = longint'(TICK_RATE) / longint'(fz);
					want.mask[n] = 1'b1;
					steps[n] = steps[n] + 1'b1;
					time_left[n] = time_left[n] + period[TICK_W-1:0];
				end
				lft = longint'($signed(time_left[n]));
				if (lft >= WAIT_HALF_LIMIT)
					prop = longint'(WAIT_CAP);
				else if (lft > WAIT_CAP)
					prop = lft / 2;
				else
					prop = lft;
				if (prop < best)
					best = prop;
			end
			if (best < WAIT_FLOOR)
				best = longint'(WAIT_FLOOR);
			if (best > WAIT_CAP)
				best = longint'(WAIT_CAP);
			last_ivl = best[LAST_W-1:0];
			want.interval = best[NEXT_W-1:0];
			for (int n = 0; n < CH; n++)
				want.posn[n] = steps[n];
			pending_reports.push_back(want);
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: result with no word pending: mask %h interval %0d",
					$time, got.mask, got.interval);
				return;
			end
			want = pending_reports.pop_front();
			if (got.mask !== want.mask) begin
				errors++;
				$display("%0t: pulse_mask expected %h actual %h", $time, want.mask, got.mask);
			end
			if (got.interval !== want.interval) begin
				errors++;
				$display("%0t: next_interval expected %0d actual %0d",
					$time, want.interval, got.interval);
			end
			for (int n = 0; n < MAX_CH; n++)
				if (got.posn[n] !== want.posn[n]) begin
					errors++;
					$display("%0t: position_%0d expected %h actual %h",
						$time, n, want.posn[n], got.posn[n]);
				end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [FREQ_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 expiry_event;
	logic                 out_valid;
	logic                 out_ready;
	logic [MASK_W-1:0]    pulse_mask;
	logic [NEXT_W-1:0]    next_interval;
	logic [POS_W-1:0]     position_0;
	logic [POS_W-1:0]     position_1;
	logic [POS_W-1:0]     position_2;
	logic [POS_W-1:0]     position_3;

	schedule_board board = new();
	bit            gaps_on = 1'b1;
	int unsigned   taken_words = 0;
	int unsigned   quiet_cycles = 0;

	multi_channel_pulse_scheduler #(
		.CHANNELS(CH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.expiry_event (expiry_event),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pulse_mask   (pulse_mask),
		.next_interval(next_interval),
		.position_0   (position_0),
		.position_1   (position_1),
		.position_2   (position_2),
		.position_3   (position_3)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			board.note_word(expiry_event);
			taken_words++;
		end
		if (out_valid && out_ready)
			board.check_report({pulse_mask, next_interval,
				position_3, position_2, position_1, position_0});
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multi_channel_pulse_scheduler regression: fail");
			$finish;
		end
	end

	initial begin : receiver
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && taken_words >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !gaps_on || ($urandom_range(99) >= 26);
			end
		end
	end

	task automatic send_word(input logic ev);
		if (gaps_on && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		expiry_event <= ev;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, drain every pending schedule, then let the bench idle before returning
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_freqs(input freq_set_t fset);
		for (int n = 0; n < MAX_CH; n++) begin
			cfg_we <= 1'b1;
			cfg_addr <= freq_reg_e'(n);
			cfg_wdata <= fset[n];
			@(posedge clk);
			board.set_freq(n, fset[n]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(5))
			0: return FREQ_W'($urandom_range(2000, 1));
			1: return FREQ_W'($urandom_range(1200, 500));
			2: return FREQ_W'($urandom_range(1000000, 1));
			3: return FREQ_W'($urandom_range(20'hFFFFF, 0));
			4: return FREQ_W'($urandom_range(1000000, 100000));
			default: begin
				case ($urandom_range(3))
					0: return '0;
					1: return FREQ_W'(1);
					2: return FREQ_W'(1000000);
					default: return '1;
				endcase
			end
		endcase
	endfunction

	initial begin : stimulus
		freq_set_t fset;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		expiry_event = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frequencies, first expiry with zero last interval, a cleared event
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b1);
		wait_idle();

		// extremes, zero frequency among them
		write_freqs({20'hFFFFF, 20'd1000000, 20'd1, 20'd0});
		for (k = 0; k < 6; k++)
			send_word(k != 2);
		wait_idle();
		write_freqs({20'd0, 20'd1, 20'd1000000, 20'hFFFFF});
		for (k = 0; k < 6; k++)
			send_word(k != 4);
		wait_idle();

		for (int phase = 0; phase < PHASES; phase++) begin
			for (int n = 0; n < MAX_CH; n++)
				fset[n] = pick_freq();
			write_freqs(fset);
			gaps_on = (phase != 3);
			k = 0;
			while (k < PHASE_WORDS) begin
				if (phase == 5 && k == PHASE_WORDS / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (board.waiting() != 0)
						@(posedge clk);
				end
				if ($urandom_range(99) < 8) begin
					send_word(1'b0);
				end else begin
					send_word(1'b1);
					k++;
				end
			end
			gaps_on = 1'b1;
			wait_idle();
		end

		if (board.errors == 0)
			$display("multi_channel_pulse_scheduler regression: pass");
		else
			$display("multi_channel_pulse_scheduler regression: fail");
		$finish;
	end

endmodule
